// ===== rtl/ptb_pkg.sv =====
// Package for the publish throttle with reconnect backoff.
// Holds command and pressure codes, register indexes, reset values and stream word layouts.
// No dependencies; used by the top level and its checker.
package ptb_pkg;

    localparam int CMD_W       = 3;
    localparam int LEVEL_W     = 2;
    localparam int DELAY_W     = 24;
    localparam int INTERVAL_W  = 24;
    localparam int FACTOR_W    = 5;
    localparam int HEAP_W      = 32;
    localparam int TIME_W      = 32;
    localparam int ATTEMPT_W   = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;
    localparam int SCALED_W    = INTERVAL_W + 2;
    localparam int PROD_W      = DELAY_W + FACTOR_W;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CONN_UPDATE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUB_QUERY     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUB_DONE      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RECONN_FAIL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RECONN_OK     = 3'd4;

    // Pressure levels
    localparam logic [LEVEL_W-1:0] LVL_OK       = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_MODERATE = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_HIGH     = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_CRITICAL = 2'd3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PUBLISH_INTERVAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_DELAY       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DELAY        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_FACTOR   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CRITICAL_HEAP    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_HEAP        = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MODERATE_HEAP    = 3'd6;

    // Reset values
    localparam logic [INTERVAL_W-1:0] RST_PUBLISH_INTERVAL = 24'd0;
    localparam logic [DELAY_W-1:0]    RST_BASE_DELAY       = 24'd1000;
    localparam logic [DELAY_W-1:0]    RST_MAX_DELAY        = 24'd60000;
    localparam logic [FACTOR_W-1:0]   RST_BACKOFF_FACTOR   = 5'd2;
    localparam logic [HEAP_W-1:0]     RST_CRITICAL_HEAP    = 32'd10240;
    localparam logic [HEAP_W-1:0]     RST_HIGH_HEAP        = 32'd32768;
    localparam logic [HEAP_W-1:0]     RST_MODERATE_HEAP    = 32'd65536;

    localparam logic [SCALED_W-1:0]   DEFAULT_INTERVAL     = 26'd1000;

    typedef struct packed {
        logic [6:0]        pad;
        logic [TIME_W-1:0] now_ms;
        logic [HEAP_W-1:0] free_memory;
        logic              link_is_up;
    } in_word_t;

    typedef struct packed {
        logic [2:0]           pad;
        logic                 link_up_now;
        logic                 retry_waiting;
        logic [ATTEMPT_W-1:0] failed_attempts;
        logic [DELAY_W-1:0]   retry_delay_ms;
        logic                 publish_allowed;
        logic [LEVEL_W-1:0]   pressure_level;
    } out_word_t;

endpackage

// ===== rtl/publish_throttle_with_backoff.sv =====
// Publish throttle with memory pressure class and exponential reconnect backoff.
// One input register stage, one result register stage; depends on ptb_pkg.
//
// Usage:
//   Link events enter on the s_ stream: s_tuser carries the command, s_tdata the
//   link flag, free memory and current time. Each event yields exactly one
//   status word on the m_ stream: pressure level, publish decision, current
//   reconnect delay, failure count, retry wait flag and link state.
//   The user must write configuration registers through cfg_we/cfg_index/cfg_data
//   only while no event is in flight, unchecked by the block; index 7 writes are ignored.
// Timing:
//   An event is held in the input register, then its state update and result
//   are computed in a single combinational pass (32-bit wrap subtract and
//   compare, 24x5 multiply with clamp) and land in the result register.
//   Throughput is one event per cycle while m_tready is high.
// Reset:
//   rst_n clears both stages, returns the registers to their defaults, and sets
//   the link up, pressure ok, delay 1000 ms, no failures.
// Back-pressure:
//   While m_tready is low the result word holds; the input register still takes
//   one more event, then s_tready drops until the result is taken.
module publish_throttle_with_backoff
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] link_is_up, [32:1] free_memory, [64:33] now_ms, [71:65] zero
    input  logic [ptb_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [2:0] command
    input  logic [ptb_pkg::CMD_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] pressure_level, [2] publish_allowed, [26:3] retry_delay_ms,
    // [42:27] failed_attempts, [43] retry_waiting, [44] link_up_now, [47:45] zero
    output logic [ptb_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [ptb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ptb_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ptb_pkg::*;

    // Configuration registers
    logic [INTERVAL_W-1:0] publish_interval_reg;
    logic [DELAY_W-1:0]    base_delay_reg;
    logic [DELAY_W-1:0]    max_delay_reg;
    logic [FACTOR_W-1:0]   backoff_factor_reg;
    logic [HEAP_W-1:0]     critical_heap_reg;
    logic [HEAP_W-1:0]     high_heap_reg;
    logic [HEAP_W-1:0]     moderate_heap_reg;

    // Input stage
    logic              s1_valid_reg;
    logic [CMD_W-1:0]  s1_cmd_reg;
    in_word_t          s1_word_reg;
    logic              s1_fire;

    // Block state
    logic [LEVEL_W-1:0]   pressure_reg, pressure_next;
    logic                 link_reg, link_next;
    logic [TIME_W-1:0]    last_pub_reg, last_pub_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic [ATTEMPT_W-1:0] attempt_reg, attempt_next;
    logic                 waiting_reg, waiting_next;
    logic                 allowed;

    // Result stage
    logic       m_valid_reg;
    out_word_t  m_word_reg, m_word_next;

    logic [LEVEL_W-1:0]  level_update;
    logic [SCALED_W-1:0] interval_scaled;
    logic [SCALED_W-1:0] interval_eff;
    logic [TIME_W-1:0]   elapsed;
    logic                pub_ok;
    logic [PROD_W-1:0]   prod;
    logic [DELAY_W-1:0]  delay_fail;

    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            publish_interval_reg <= RST_PUBLISH_INTERVAL;
            base_delay_reg       <= RST_BASE_DELAY;
            max_delay_reg        <= RST_MAX_DELAY;
            backoff_factor_reg   <= RST_BACKOFF_FACTOR;
            critical_heap_reg    <= RST_CRITICAL_HEAP;
            high_heap_reg        <= RST_HIGH_HEAP;
            moderate_heap_reg    <= RST_MODERATE_HEAP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PUBLISH_INTERVAL: publish_interval_reg <= cfg_data[INTERVAL_W-1:0];
                REG_BASE_DELAY:       base_delay_reg       <= cfg_data[DELAY_W-1:0];
                REG_MAX_DELAY:        max_delay_reg        <= cfg_data[DELAY_W-1:0];
                REG_BACKOFF_FACTOR:   backoff_factor_reg   <= cfg_data[FACTOR_W-1:0];
                REG_CRITICAL_HEAP:    critical_heap_reg    <= cfg_data[HEAP_W-1:0];
                REG_HIGH_HEAP:        high_heap_reg        <= cfg_data[HEAP_W-1:0];
                REG_MODERATE_HEAP:    moderate_heap_reg    <= cfg_data[HEAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_cmd_reg  <= s_tuser;
            s1_word_reg <= s_tdata;
        end
    end

    // Pressure class for a connection update
    always_comb
    begin
        priority if (!s1_word_reg.link_is_up)
            level_update = LVL_HIGH;
        else if (s1_word_reg.free_memory < critical_heap_reg)
            level_update = LVL_CRITICAL;
        else if (s1_word_reg.free_memory < high_heap_reg)
            level_update = LVL_HIGH;
        else if (s1_word_reg.free_memory < moderate_heap_reg)
            level_update = LVL_MODERATE;
        else
            level_update = LVL_OK;
    end

    // Publish decision: moderate pressure stretches the interval by four
    assign interval_scaled = (pressure_reg == LVL_MODERATE) ? {publish_interval_reg, 2'b00}
                                                            : {2'b00, publish_interval_reg};
    assign interval_eff = (interval_scaled == '0) ? DEFAULT_INTERVAL : interval_scaled;
    assign elapsed      = s1_word_reg.now_ms - last_pub_reg;
    assign pub_ok       = link_reg
                          && (pressure_reg == LVL_OK || pressure_reg == LVL_MODERATE)
                          && (elapsed >= {{(TIME_W-SCALED_W){1'b0}}, interval_eff});

    // Backoff: wide product, clamp before truncating
    assign prod       = PROD_W'(delay_reg) * PROD_W'(backoff_factor_reg);
    assign delay_fail = (prod > PROD_W'(max_delay_reg)) ? max_delay_reg : prod[DELAY_W-1:0];

    always_comb
    begin
        pressure_next = pressure_reg;
        link_next     = link_reg;
        last_pub_next = last_pub_reg;
        delay_next    = delay_reg;
        attempt_next  = attempt_reg;
        waiting_next  = waiting_reg;
        allowed       = 1'b0;
        unique case (s1_cmd_reg)
            CMD_CONN_UPDATE:
            begin
                link_next     = s1_word_reg.link_is_up;
                pressure_next = level_update;
            end
            CMD_PUB_QUERY:
            begin
                allowed = pub_ok;
            end
            CMD_PUB_DONE:
            begin
                last_pub_next = s1_word_reg.now_ms;
            end
            CMD_RECONN_FAIL:
            begin
                if (attempt_reg != '1)
                begin
                    attempt_next = attempt_reg + 1'b1;
                end
                delay_next   = delay_fail;
                waiting_next = 1'b1;
            end
            CMD_RECONN_OK:
            begin
                attempt_next = '0;
                delay_next   = base_delay_reg;
                waiting_next = 1'b0;
                link_next    = 1'b1;
            end
            default: ;
        endcase

        m_word_next                 = '0;
        m_word_next.pressure_level  = pressure_next;
        m_word_next.publish_allowed = allowed;
        m_word_next.retry_delay_ms  = delay_next;
        m_word_next.failed_attempts = attempt_next;
        m_word_next.retry_waiting   = waiting_next;
        m_word_next.link_up_now     = link_next;
    end

    // State and result advance together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressure_reg <= LVL_OK;
            link_reg     <= 1'b1;
            last_pub_reg <= '0;
            delay_reg    <= RST_BASE_DELAY;
            attempt_reg  <= '0;
            waiting_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                pressure_reg <= pressure_next;
                link_reg     <= link_next;
                last_pub_reg <= last_pub_next;
                delay_reg    <= delay_next;
                attempt_reg  <= attempt_next;
                waiting_reg  <= waiting_next;
                m_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            m_word_reg <= m_word_next;
        end
    end

endmodule

// ===== rtl/ptb_checker.sv =====
// Port-level checker for publish_throttle_with_backoff, bound to the top level.
// Depends on ptb_pkg for the result word layout and pressure codes.
module ptb_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ptb_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import ptb_pkg::*;

    out_word_t word;
    assign word = m_tdata;

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // A granted publish needs the link up and low pressure
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && word.publish_allowed |->
            word.link_up_now
            && (word.pressure_level == LVL_OK || word.pressure_level == LVL_MODERATE))
        else $error("publish granted with link down or high pressure");

    // Waiting for a retry exactly when failures are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> word.retry_waiting == (word.failed_attempts != '0))
        else $error("retry wait flag disagrees with failure count");

    // Link down only comes from an update, which classifies as high
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !word.link_up_now |-> word.pressure_level == LVL_HIGH)
        else $error("link down without high pressure");

endmodule

bind publish_throttle_with_backoff ptb_checker u_ptb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
